// ----- design/mlrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrs_pkg
// Shared constants, codes and controller/datapath interface types for the
// memory link request scheduler.
// ----------------------------------------------------------------------------
package mlrs_pkg;

  // Queue geometry
  localparam int RQ_DEPTH = 16;
  localparam int WQ_DEPTH = 16;
  localparam int SQ_DEPTH = 16;
  localparam int RQ_IW = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
  localparam int WQ_IW = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;
  localparam int SQ_IW = (SQ_DEPTH > 1) ? $clog2(SQ_DEPTH) : 1;
  localparam int MAX_IW = (RQ_IW > WQ_IW) ? ((RQ_IW > SQ_IW) ? RQ_IW : SQ_IW)
                                          : ((WQ_IW > SQ_IW) ? WQ_IW : SQ_IW);

  // Cache line offset bits
  localparam int LINE_SHIFT = 6;

  // Configuration register indexes
  localparam logic [1:0] CFG_WARMUP = 2'd0;
  localparam logic [1:0] CFG_LAT    = 2'd1;
  localparam logic [1:0] CFG_RXF    = 2'd2;
  localparam logic [1:0] CFG_WXF    = 2'd3;

  typedef enum logic [1:0] {
    K_TICK  = 2'd0,
    K_READ  = 2'd1,
    K_WRITE = 2'd2,
    K_RESP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OK_STATUS = 3'd0,
    OK_RESP   = 3'd1,
    OK_LREAD  = 3'd2,
    OK_LWRITE = 3'd3,
    OK_TICK   = 3'd4
  } okind_t;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_COALESCED = 3'd2,
    ST_FORWARDED = 3'd3,
    ST_WU_DROP   = 3'd4,
    ST_WU_ANS    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    Q_RD = 2'd0,
    Q_WR = 2'd1,
    Q_RS = 2'd2
  } queue_t;

  typedef enum logic [2:0] {
    ES_BEST = 3'd0,
    ES_SCAN = 3'd1,
    ES_WACT = 3'd2,
    ES_RACT = 3'd3,
    ES_WHIT = 3'd4
  } ent_src_t;

  typedef enum logic [1:0] {
    OS_IN   = 2'd0,
    OS_ENT  = 2'd1,
    OS_TICK = 2'd2
  } out_src_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOOK,
    S_DISP,
    S_FWD_ST,
    S_FWD_RSP,
    S_WU_RSP,
    S_RS_CHK,
    S_RS_SCAN,
    S_RS_GRAB,
    S_WR_BEGIN,
    S_WR_CHK,
    S_WR_SCAN,
    S_WR_GRAB,
    S_RD_SCAN,
    S_RD_PICK,
    S_RD_EMIT,
    S_WU_LD,
    S_WU_CHK,
    S_TICK_DONE
  } ctl_state_t;

  typedef struct packed {
    logic       warmup;
    logic [9:0] lat;
    logic [9:0] rxf;
    logic [9:0] wxf;
  } cfg_t;

  typedef struct packed {
    logic     latch_in;
    logic     lookup;
    logic     ent_load;
    ent_src_t ent_src;
    logic     out_load;
    out_src_t out_src;
    okind_t   out_kind;
    status_t  out_status;
    logic     out_data_ent;
    logic     out_last;
    logic     rq_fill;
    logic     wq_fill;
    logic     sq_fill;
    logic     wq_replace;
    logic     rq_coalesce;
    logic     ent_clear;
    logic     bus_release;
    logic     scan_start;
    queue_t   scan_q;
    logic     scan_step;
    logic     bus_grab;
    logic     wu_clear;
    logic     tick_inc;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  warmup;
    logic  want;
    logic  wq_hit;
    logic  rq_hit;
    logic  rq_free;
    logic  wq_free;
    logic  sq_free;
    logic  ent_ready;
    logic  ent_vw;
    logic  rs_busy;
    logic  wr_busy;
    logic  scan_last;
    logic  best_found;
    logic  out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- design/mlrs_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrs_cfg
// APB register file: warmup mode, link latency and the two bus transfer times.
// ----------------------------------------------------------------------------
module mlrs_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output mlrs_pkg::cfg_t    cfg
);
  import mlrs_pkg::*;

  logic       warmup_r;
  logic [9:0] lat_r;
  logic [9:0] rxf_r;
  logic [9:0] wxf_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r <= 1'b0;
      lat_r    <= 10'd10;
      rxf_r    <= 10'd4;
      wxf_r    <= 10'd4;
    end else if (wr_en) begin
      case (paddr[3:2])
        CFG_WARMUP: warmup_r <= pwdata[0];
        CFG_LAT:    lat_r    <= pwdata[9:0];
        CFG_RXF:    rxf_r    <= pwdata[9:0];
        CFG_WXF:    wxf_r    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      CFG_WARMUP: prdata = {31'd0, warmup_r};
      CFG_LAT:    prdata = {22'd0, lat_r};
      CFG_RXF:    prdata = {22'd0, rxf_r};
      CFG_WXF:    prdata = {22'd0, wxf_r};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg = '{warmup: warmup_r, lat: lat_r, rxf: rxf_r, wxf: wxf_r};

endmodule
`default_nettype wire

// ----- design/mlrs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrs_ctrl
// Sequencer: classifies each transaction, walks the tick through response bus,
// write bus and read issue, and drives datapath commands.
// ----------------------------------------------------------------------------
module mlrs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mlrs_pkg::dp_stat_t stat,
  output mlrs_pkg::ctl_cmd_t      cmd
);
  import mlrs_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: state_nxt = S_DISP;
      S_DISP: begin
        case (stat.kind)
          K_TICK: begin
            if (stat.warmup)       state_nxt = S_WU_LD;
            else if (stat.rs_busy) state_nxt = S_RS_CHK;
            else                   state_nxt = S_RS_SCAN;
          end
          K_READ: begin
            if (stat.warmup) begin
              if (stat.out_free) state_nxt = stat.want ? S_WU_RSP : S_IDLE;
            end else if (stat.wq_hit) begin
              state_nxt = S_FWD_ST;
            end else if (stat.out_free) begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (stat.out_free) state_nxt = S_IDLE;
          end
        endcase
      end
      S_FWD_ST: begin
        if (stat.out_free) state_nxt = stat.want ? S_FWD_RSP : S_IDLE;
      end
      S_FWD_RSP, S_WU_RSP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_RS_CHK: begin
        if (!stat.ent_ready)    state_nxt = S_WR_BEGIN;
        else if (stat.out_free) state_nxt = S_RS_SCAN;
      end
      S_RS_SCAN: begin
        if (stat.scan_last) state_nxt = S_RS_GRAB;
      end
      S_RS_GRAB: state_nxt = S_WR_BEGIN;
      S_WR_BEGIN: state_nxt = stat.wr_busy ? S_WR_CHK : S_WR_SCAN;
      S_WR_CHK: begin
        if (!stat.ent_ready)    state_nxt = S_RD_SCAN;
        else if (stat.out_free) state_nxt = S_WR_SCAN;
      end
      S_WR_SCAN: begin
        if (stat.scan_last) state_nxt = S_WR_GRAB;
      end
      S_WR_GRAB: state_nxt = S_RD_SCAN;
      S_RD_SCAN: begin
        if (stat.scan_last) state_nxt = S_RD_PICK;
      end
      S_RD_PICK: state_nxt = stat.best_found ? S_RD_EMIT : S_TICK_DONE;
      S_RD_EMIT: begin
        if (stat.out_free) state_nxt = S_RD_SCAN;
      end
      S_WU_LD: state_nxt = S_WU_CHK;
      S_WU_CHK: begin
        if (!stat.ent_vw || stat.out_free) begin
          state_nxt = stat.scan_last ? S_TICK_DONE : S_WU_LD;
        end
      end
      S_TICK_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_LOOK: cmd.lookup = 1'b1;
      S_DISP: begin
        case (stat.kind)
          K_TICK: begin
            if (stat.warmup) begin
              cmd.scan_start = 1'b1;
              cmd.scan_q     = Q_RD;
            end else if (stat.rs_busy) begin
              cmd.ent_load = 1'b1;
              cmd.ent_src  = ES_RACT;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.scan_q     = Q_RS;
            end
          end
          K_READ: begin
            if (stat.warmup) begin
              cmd.out_load   = stat.out_free;
              cmd.out_status = ST_WU_ANS;
              cmd.out_last   = !stat.want;
            end else if (stat.wq_hit) begin
              cmd.ent_load = 1'b1;
              cmd.ent_src  = ES_WHIT;
            end else if (stat.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (stat.rq_hit) begin
                cmd.rq_coalesce = 1'b1;
                cmd.out_status  = ST_COALESCED;
              end else if (stat.rq_free) begin
                cmd.rq_fill    = 1'b1;
                cmd.out_status = ST_QUEUED;
              end else begin
                cmd.out_status = ST_FULL;
              end
            end
          end
          K_WRITE: begin
            if (stat.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (stat.warmup) begin
                cmd.out_status = ST_WU_DROP;
              end else if (stat.wq_hit) begin
                cmd.wq_replace = 1'b1;
                cmd.out_status = ST_COALESCED;
              end else if (stat.wq_free) begin
                cmd.wq_fill    = 1'b1;
                cmd.out_status = ST_QUEUED;
              end else begin
                cmd.out_status = ST_FULL;
              end
            end
          end
          default: begin
            if (stat.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.sq_fill    = stat.sq_free;
              cmd.out_status = stat.sq_free ? ST_QUEUED : ST_FULL;
            end
          end
        endcase
      end
      S_FWD_ST: begin
        cmd.out_load     = stat.out_free;
        cmd.out_status   = ST_FORWARDED;
        cmd.out_data_ent = 1'b1;
        cmd.out_last     = !stat.want;
      end
      S_FWD_RSP: begin
        cmd.out_load     = stat.out_free;
        cmd.out_kind     = OK_RESP;
        cmd.out_data_ent = 1'b1;
        cmd.out_last     = 1'b1;
      end
      S_WU_RSP: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = OK_RESP;
        cmd.out_last = 1'b1;
      end
      S_RS_CHK, S_WR_CHK: begin
        // Retire the active bus transaction once its transfer time is over
        if (stat.ent_ready && stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_src      = OS_ENT;
          cmd.out_kind     = (state_r == S_RS_CHK) ? OK_RESP : OK_LWRITE;
          cmd.out_data_ent = 1'b1;
          cmd.ent_clear    = 1'b1;
          cmd.bus_release  = 1'b1;
          cmd.scan_start   = 1'b1;
          cmd.scan_q       = (state_r == S_RS_CHK) ? Q_RS : Q_WR;
        end else if (!stat.ent_ready && state_r == S_WR_CHK) begin
          cmd.scan_start = 1'b1;
          cmd.scan_q     = Q_RD;
        end
      end
      S_RS_SCAN, S_WR_SCAN, S_RD_SCAN: cmd.scan_step = 1'b1;
      S_RS_GRAB: cmd.bus_grab = stat.best_found;
      S_WR_BEGIN: begin
        if (stat.wr_busy) begin
          cmd.ent_load = 1'b1;
          cmd.ent_src  = ES_WACT;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_q     = Q_WR;
        end
      end
      S_WR_GRAB: begin
        cmd.bus_grab   = stat.best_found;
        cmd.scan_start = 1'b1;
        cmd.scan_q     = Q_RD;
      end
      S_RD_PICK: begin
        cmd.ent_load = stat.best_found;
        cmd.ent_src  = ES_BEST;
      end
      S_RD_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = OS_ENT;
          cmd.out_kind   = OK_LREAD;
          cmd.ent_clear  = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.scan_q     = Q_RD;
        end
      end
      S_WU_LD: begin
        cmd.ent_load = 1'b1;
        cmd.ent_src  = ES_SCAN;
      end
      S_WU_CHK: begin
        // Answer a waiting read, then drop the entry
        if (!stat.ent_vw || stat.out_free) begin
          cmd.out_load  = stat.ent_vw;
          cmd.out_src   = OS_ENT;
          cmd.out_kind  = OK_RESP;
          cmd.ent_clear = 1'b1;
          cmd.scan_step = !stat.scan_last;
          cmd.wu_clear  = stat.scan_last;
        end
      end
      S_TICK_DONE: begin
        cmd.out_load = stat.out_free;
        cmd.out_src  = OS_TICK;
        cmd.out_kind = OK_TICK;
        cmd.out_last = 1'b1;
        cmd.tick_inc = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/mlrs_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrs_dp
// Datapath: queue state, line lookup, age scan engine, payload memories and
// the output register.
// ----------------------------------------------------------------------------
module mlrs_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mlrs_pkg::cfg_t     cfg,
  input  wire mlrs_pkg::ctl_cmd_t cmd,
  output mlrs_pkg::dp_stat_t      stat,
  input  wire logic [1:0]         in_kind,
  input  wire logic [63:0]        in_address,
  input  wire logic [63:0]        in_payload,
  input  wire logic [31:0]        in_metadata,
  input  wire logic               in_wants_response,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_kind,
  output logic [2:0]              out_status,
  output logic [63:0]             out_address,
  output logic [63:0]             out_data,
  output logic [31:0]             out_metadata,
  output logic                    out_last
);
  import mlrs_pkg::*;

  // Latched transaction
  logic [1:0]  in_kind_r;
  logic [63:0] in_addr_r;
  logic [63:0] in_data_r;
  logic [31:0] in_meta_r;
  logic        in_want_r;

  // Queue state
  logic [RQ_DEPTH-1:0] rq_vld_r;
  logic [RQ_DEPTH-1:0] rq_want_r;
  logic [31:0]         rq_rdy_r  [RQ_DEPTH];
  logic [63:0]         rq_addr_r [RQ_DEPTH];
  logic [31:0]         rq_mem    [RQ_DEPTH];
  logic [31:0]         rq_rd_r;
  logic [WQ_DEPTH-1:0] wq_vld_r;
  logic [31:0]         wq_rdy_r  [WQ_DEPTH];
  logic [63:0]         wq_addr_r [WQ_DEPTH];
  logic [95:0]         wq_mem    [WQ_DEPTH];
  logic [95:0]         wq_rd_r;
  logic [SQ_DEPTH-1:0] sq_vld_r;
  logic [31:0]         sq_rdy_r  [SQ_DEPTH];
  logic [63:0]         sq_addr_r [SQ_DEPTH];
  logic [95:0]         sq_mem    [SQ_DEPTH];
  logic [95:0]         sq_rd_r;

  logic             wr_busy_r;
  logic [WQ_IW-1:0] wr_slot_r;
  logic             rs_busy_r;
  logic [SQ_IW-1:0] rs_slot_r;
  logic [31:0]      tick_r;

  // Lookup results
  logic             wq_hit_c, rq_hit_c, rq_free_c, wq_free_c, sq_free_c;
  logic [WQ_IW-1:0] wq_hidx_c, wq_fidx_c;
  logic [RQ_IW-1:0] rq_hidx_c, rq_fidx_c;
  logic [SQ_IW-1:0] sq_fidx_c;
  logic             wq_hit_r, rq_hit_r, rq_free_r, wq_free_r, sq_free_r;
  logic [WQ_IW-1:0] wq_hidx_r, wq_fidx_r;
  logic [RQ_IW-1:0] rq_hidx_r, rq_fidx_r;
  logic [SQ_IW-1:0] sq_fidx_r;

  // Selected entry
  queue_t            ent_q_r, ent_q_nxt;
  logic [MAX_IW-1:0] ent_idx_r, ent_idx_nxt;
  logic              ent_vld, ent_want;
  logic [31:0]       ent_rdy, ent_age, ent_meta;
  logic [63:0]       ent_addr, ent_data;
  logic              ent_ready;

  // Scan engine
  queue_t            scan_q_r;
  logic [MAX_IW-1:0] scan_idx_r;
  logic              best_found_r;
  logic [MAX_IW-1:0] best_idx_r;
  logic [31:0]       best_age_r;
  logic              sc_vld, sc_ok, sc_better, scan_last;
  logic [31:0]       sc_rdy, sc_age;

  // Output register
  logic        out_valid_r;
  logic [2:0]  out_kind_r, out_status_r;
  logic [63:0] out_addr_r, out_data_r;
  logic [31:0] out_meta_r;
  logic        out_last_r;
  logic        out_free;

  logic [31:0] lat_ext, rxf_ext, wxf_ext;

  assign lat_ext = {22'd0, cfg.lat};
  assign rxf_ext = {22'd0, cfg.rxf};
  assign wxf_ext = {22'd0, cfg.wxf};

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_kind_r <= in_kind;
      in_addr_r <= in_address;
      in_data_r <= in_payload;
      in_meta_r <= in_metadata;
      in_want_r <= in_wants_response;
    end
  end

  // Compare the line against every queue entry, lowest index wins
  always_comb begin
    wq_hit_c  = 1'b0;
    wq_hidx_c = '0;
    wq_free_c = 1'b0;
    wq_fidx_c = '0;
    for (int i = WQ_DEPTH - 1; i >= 0; i--) begin
      if (wq_vld_r[i] && wq_addr_r[i][63:LINE_SHIFT] == in_addr_r[63:LINE_SHIFT]) begin
        wq_hit_c  = 1'b1;
        wq_hidx_c = WQ_IW'(i);
      end
      if (!wq_vld_r[i]) begin
        wq_free_c = 1'b1;
        wq_fidx_c = WQ_IW'(i);
      end
    end
  end

  always_comb begin
    rq_hit_c  = 1'b0;
    rq_hidx_c = '0;
    rq_free_c = 1'b0;
    rq_fidx_c = '0;
    for (int i = RQ_DEPTH - 1; i >= 0; i--) begin
      if (rq_vld_r[i] && rq_addr_r[i][63:LINE_SHIFT] == in_addr_r[63:LINE_SHIFT]) begin
        rq_hit_c  = 1'b1;
        rq_hidx_c = RQ_IW'(i);
      end
      if (!rq_vld_r[i]) begin
        rq_free_c = 1'b1;
        rq_fidx_c = RQ_IW'(i);
      end
    end
  end

  always_comb begin
    sq_free_c = 1'b0;
    sq_fidx_c = '0;
    for (int i = SQ_DEPTH - 1; i >= 0; i--) begin
      if (!sq_vld_r[i]) begin
        sq_free_c = 1'b1;
        sq_fidx_c = SQ_IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      wq_hit_r  <= wq_hit_c;
      wq_hidx_r <= wq_hidx_c;
      wq_free_r <= wq_free_c;
      wq_fidx_r <= wq_fidx_c;
      rq_hit_r  <= rq_hit_c;
      rq_hidx_r <= rq_hidx_c;
      rq_free_r <= rq_free_c;
      rq_fidx_r <= rq_fidx_c;
      sq_free_r <= sq_free_c;
      sq_fidx_r <= sq_fidx_c;
    end
  end

  // Choose which entry to address
  always_comb begin
    case (cmd.ent_src)
      ES_BEST: begin
        ent_q_nxt   = scan_q_r;
        ent_idx_nxt = best_idx_r;
      end
      ES_SCAN: begin
        ent_q_nxt   = Q_RD;
        ent_idx_nxt = scan_idx_r;
      end
      ES_WACT: begin
        ent_q_nxt   = Q_WR;
        ent_idx_nxt = MAX_IW'(wr_slot_r);
      end
      ES_RACT: begin
        ent_q_nxt   = Q_RS;
        ent_idx_nxt = MAX_IW'(rs_slot_r);
      end
      ES_WHIT: begin
        ent_q_nxt   = Q_WR;
        ent_idx_nxt = MAX_IW'(wq_hidx_r);
      end
      default: begin
        ent_q_nxt   = Q_RD;
        ent_idx_nxt = '0;
      end
    endcase
  end

  // Payload memories: fill/replace writes, registered reads
  always_ff @(posedge clk) begin
    if (cmd.rq_fill) rq_mem[rq_fidx_r] <= in_meta_r;
    if (cmd.wq_fill) wq_mem[wq_fidx_r] <= {in_data_r, in_meta_r};
    if (cmd.wq_replace) wq_mem[wq_hidx_r] <= {in_data_r, in_meta_r};
    if (cmd.sq_fill) sq_mem[sq_fidx_r] <= {in_data_r, in_meta_r};
    if (cmd.ent_load) begin
      ent_q_r   <= ent_q_nxt;
      ent_idx_r <= ent_idx_nxt;
      rq_rd_r   <= rq_mem[ent_idx_nxt[RQ_IW-1:0]];
      wq_rd_r   <= wq_mem[ent_idx_nxt[WQ_IW-1:0]];
      sq_rd_r   <= sq_mem[ent_idx_nxt[SQ_IW-1:0]];
    end
  end

  // View of the addressed entry
  always_comb begin
    case (ent_q_r)
      Q_WR: begin
        ent_vld  = wq_vld_r[ent_idx_r[WQ_IW-1:0]];
        ent_want = 1'b0;
        ent_rdy  = wq_rdy_r[ent_idx_r[WQ_IW-1:0]];
        ent_addr = wq_addr_r[ent_idx_r[WQ_IW-1:0]];
        ent_data = wq_rd_r[95:32];
        ent_meta = wq_rd_r[31:0];
      end
      Q_RS: begin
        ent_vld  = sq_vld_r[ent_idx_r[SQ_IW-1:0]];
        ent_want = 1'b1;
        ent_rdy  = sq_rdy_r[ent_idx_r[SQ_IW-1:0]];
        ent_addr = sq_addr_r[ent_idx_r[SQ_IW-1:0]];
        ent_data = sq_rd_r[95:32];
        ent_meta = sq_rd_r[31:0];
      end
      default: begin
        ent_vld  = rq_vld_r[ent_idx_r[RQ_IW-1:0]];
        ent_want = rq_want_r[ent_idx_r[RQ_IW-1:0]];
        ent_rdy  = rq_rdy_r[ent_idx_r[RQ_IW-1:0]];
        ent_addr = rq_addr_r[ent_idx_r[RQ_IW-1:0]];
        ent_data = 64'd0;
        ent_meta = rq_rd_r;
      end
    endcase
  end

  assign ent_age   = tick_r - ent_rdy;
  assign ent_ready = ent_vld & ~ent_age[31];

  // One entry per cycle: keep the oldest ready one
  always_comb begin
    case (scan_q_r)
      Q_WR: begin
        sc_vld    = wq_vld_r[scan_idx_r[WQ_IW-1:0]];
        sc_rdy    = wq_rdy_r[scan_idx_r[WQ_IW-1:0]];
        scan_last = (scan_idx_r == MAX_IW'(WQ_DEPTH - 1));
      end
      Q_RS: begin
        sc_vld    = sq_vld_r[scan_idx_r[SQ_IW-1:0]];
        sc_rdy    = sq_rdy_r[scan_idx_r[SQ_IW-1:0]];
        scan_last = (scan_idx_r == MAX_IW'(SQ_DEPTH - 1));
      end
      default: begin
        sc_vld    = rq_vld_r[scan_idx_r[RQ_IW-1:0]];
        sc_rdy    = rq_rdy_r[scan_idx_r[RQ_IW-1:0]];
        scan_last = (scan_idx_r == MAX_IW'(RQ_DEPTH - 1));
      end
    endcase
  end

  assign sc_age    = tick_r - sc_rdy;
  assign sc_ok     = sc_vld & ~sc_age[31];
  assign sc_better = sc_ok & (!best_found_r | (sc_age > best_age_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (cmd.scan_start) begin
      best_found_r <= 1'b0;
    end else if (cmd.scan_step && sc_better) begin
      best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_q_r   <= cmd.scan_q;
      scan_idx_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (sc_better) begin
        best_idx_r <= scan_idx_r;
        best_age_r <= sc_age;
      end
    end
  end

  // Valid bits, bus slots and tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_vld_r  <= '0;
      wq_vld_r  <= '0;
      sq_vld_r  <= '0;
      wr_busy_r <= 1'b0;
      wr_slot_r <= '0;
      rs_busy_r <= 1'b0;
      rs_slot_r <= '0;
      tick_r    <= '0;
    end else begin
      if (cmd.rq_fill) rq_vld_r[rq_fidx_r] <= 1'b1;
      if (cmd.wq_fill) wq_vld_r[wq_fidx_r] <= 1'b1;
      if (cmd.sq_fill) sq_vld_r[sq_fidx_r] <= 1'b1;
      if (cmd.ent_clear) begin
        case (ent_q_r)
          Q_WR:    wq_vld_r[ent_idx_r[WQ_IW-1:0]] <= 1'b0;
          Q_RS:    sq_vld_r[ent_idx_r[SQ_IW-1:0]] <= 1'b0;
          default: rq_vld_r[ent_idx_r[RQ_IW-1:0]] <= 1'b0;
        endcase
      end
      if (cmd.bus_release) begin
        if (ent_q_r == Q_WR) wr_busy_r <= 1'b0;
        if (ent_q_r == Q_RS) rs_busy_r <= 1'b0;
      end
      if (cmd.bus_grab) begin
        if (scan_q_r == Q_WR) begin
          wr_busy_r <= 1'b1;
          wr_slot_r <= best_idx_r[WQ_IW-1:0];
        end
        if (scan_q_r == Q_RS) begin
          rs_busy_r <= 1'b1;
          rs_slot_r <= best_idx_r[SQ_IW-1:0];
        end
      end
      if (cmd.wu_clear) begin
        wq_vld_r  <= '0;
        wr_busy_r <= 1'b0;
      end
      if (cmd.tick_inc) tick_r <= tick_r + 32'd1;
    end
  end

  // Entry fields held in flops
  always_ff @(posedge clk) begin
    if (cmd.rq_fill) begin
      rq_want_r[rq_fidx_r] <= in_want_r;
      rq_rdy_r[rq_fidx_r]  <= tick_r + lat_ext;
      rq_addr_r[rq_fidx_r] <= in_addr_r;
    end
    if (cmd.rq_coalesce) rq_want_r[rq_hidx_r] <= rq_want_r[rq_hidx_r] | in_want_r;
    if (cmd.wq_fill) begin
      wq_rdy_r[wq_fidx_r]  <= tick_r + lat_ext;
      wq_addr_r[wq_fidx_r] <= in_addr_r;
    end
    if (cmd.sq_fill) begin
      sq_rdy_r[sq_fidx_r]  <= tick_r + lat_ext;
      sq_addr_r[sq_fidx_r] <= in_addr_r;
    end
    if (cmd.bus_grab) begin
      if (scan_q_r == Q_WR) wq_rdy_r[best_idx_r[WQ_IW-1:0]] <= tick_r + wxf_ext;
      if (scan_q_r == Q_RS) sq_rdy_r[best_idx_r[SQ_IW-1:0]] <= tick_r + rxf_ext;
    end
  end

  // Output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r   <= cmd.out_kind;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
      case (cmd.out_src)
        OS_ENT: begin
          out_addr_r <= ent_addr;
          out_meta_r <= ent_meta;
        end
        OS_TICK: begin
          out_addr_r <= 64'd0;
          out_meta_r <= 32'd0;
        end
        default: begin
          out_addr_r <= in_addr_r;
          out_meta_r <= in_meta_r;
        end
      endcase
      if (cmd.out_data_ent)          out_data_r <= ent_data;
      else if (cmd.out_src == OS_TICK) out_data_r <= {32'd0, tick_r};
      else                           out_data_r <= 64'd0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_status   = out_status_r;
  assign out_address  = out_addr_r;
  assign out_data     = out_data_r;
  assign out_metadata = out_meta_r;
  assign out_last     = out_last_r;

  // Status to the sequencer
  assign stat = '{
    kind:       kind_t'(in_kind_r),
    warmup:     cfg.warmup,
    want:       in_want_r,
    wq_hit:     wq_hit_r,
    rq_hit:     rq_hit_r,
    rq_free:    rq_free_r,
    wq_free:    wq_free_r,
    sq_free:    sq_free_r,
    ent_ready:  ent_ready,
    ent_vw:     ent_vld & ent_want,
    rs_busy:    rs_busy_r,
    wr_busy:    wr_busy_r,
    scan_last:  scan_last,
    best_found: best_found_r,
    out_free:   out_free
  };

endmodule
`default_nettype wire

// ----- design/memory_link_request_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// memory_link_request_scheduler
// Read, write and response queues between an upper cache and lower memory,
// with write forwarding, read coalescing and per-bus transfer timing.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A read, write or lower response passes
// through latch, lookup and dispatch states, plus a forwarding state for a
// forwarded read and one more state for each extra result. A tick walks the
// queues with one age-compare unit that checks one entry per cycle: a scan of
// the response and of the write queue for each free bus, one per read issued
// and one final read scan; a warmup tick loads and checks each read in turn.
// Output back-pressure stalls the sequence while the output register is full.
// ----------------------------------------------------------------------------
module memory_link_request_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_address,
  input  wire logic [63:0] in_payload,
  input  wire logic [31:0] in_metadata,
  input  wire logic        in_wants_response,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [2:0]       out_status,
  output logic [63:0]      out_address,
  output logic [63:0]      out_data,
  output logic [31:0]      out_metadata,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mlrs_pkg::*;

  cfg_t     cfg;
  ctl_cmd_t cmd;
  dp_stat_t stat;

  mlrs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mlrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mlrs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_kind),
    .in_address        (in_address),
    .in_payload        (in_payload),
    .in_metadata       (in_metadata),
    .in_wants_response (in_wants_response),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_address       (out_address),
    .out_data          (out_data),
    .out_metadata      (out_metadata),
    .out_last          (out_last)
  );

  // One transaction in flight: no accept right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // Only request status results carry a status code
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != OK_STATUS) |-> (out_status == ST_QUEUED))
    else $error("status code on a non-status result");

  // Tick done always closes its transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == OK_TICK) |-> out_last)
    else $error("tick done without last");

endmodule
`default_nettype wire

// ----- dv/memory_link_request_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_link_request_scheduler_tb
// Drives ticks, upper reads and writes and lower responses into the link
// scheduler, mirrors its queues and bus timing in a local model, and checks
// every emitted result in order against that model under random stalls.
// ----------------------------------------------------------------------------
module memory_link_request_scheduler_tb;
  import mlrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int QN = 16;

  typedef struct {
    bit          valid;
    bit          want;
    logic [63:0] addr;
    logic [63:0] data;
    logic [31:0] meta;
    logic [31:0] rdy;
  } slot_t;

  typedef struct {
    okind_t      kind;
    status_t     st;
    logic [63:0] addr;
    logic [63:0] data;
    logic [31:0] meta;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [63:0] in_address = '0;
  logic [63:0] in_payload = '0;
  logic [31:0] in_metadata = '0;
  logic        in_wants_response = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [2:0]  out_status;
  logic [63:0] out_address;
  logic [63:0] out_data;
  logic [31:0] out_metadata;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  memory_link_request_scheduler i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_address, .in_payload,
    .in_metadata, .in_wants_response, .out_valid, .out_ready, .out_kind,
    .out_status, .out_address, .out_data, .out_metadata, .out_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Link model state
  slot_t       link_q [3][QN];
  logic [31:0] model_tick;
  bit          model_wbusy, model_sbusy;
  int          model_wslot, model_sslot;
  bit          cfg_warmup;
  logic [9:0]  cfg_lat, cfg_rxf, cfg_wxf;

  result_t     pending_results [$];
  int          errors = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req_cnt = 0;
  int          hold_seen_cnt = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  logic [57:0] line_pool [8];

  // ---------------------------------------------------------------- model
  function automatic bit slot_ready(int qi, int i);
    logic [31:0] d;
    d = model_tick - link_q[qi][i].rdy;
    return link_q[qi][i].valid && (d < 32'h8000_0000);
  endfunction

  function automatic int oldest_ready(int qi);
    int best;
    logic [31:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < QN; i++) begin
      if (slot_ready(qi, i)) begin
        age = model_tick - link_q[qi][i].rdy;
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic int line_hit(int qi, logic [63:0] a);
    for (int i = 0; i < QN; i++)
      if (link_q[qi][i].valid && link_q[qi][i].addr[63:6] == a[63:6]) return i;
    return -1;
  endfunction

  function automatic int free_slot(int qi);
    for (int i = 0; i < QN; i++)
      if (!link_q[qi][i].valid) return i;
    return -1;
  endfunction

  task automatic expect_result(okind_t k, status_t s, logic [63:0] a, logic [63:0] d,
                               logic [31:0] m, logic l);
    result_t r;
    r.kind = k; r.st = s; r.addr = a; r.data = d; r.meta = m; r.last = l;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic fill_slot(int qi, int i, logic [63:0] a, logic [63:0] d,
                           logic [31:0] m, bit w);
    link_q[qi][i].valid = 1'b1;
    link_q[qi][i].want = w;
    link_q[qi][i].addr = a;
    link_q[qi][i].data = d;
    link_q[qi][i].meta = m;
    link_q[qi][i].rdy = model_tick + 32'(cfg_lat);
  endtask

  task automatic predict_tick();
    logic [31:0] now;
    bit hold;
    int i;
    now = model_tick;
    if (cfg_warmup) begin
      // Answer and drop all reads, flush writes and the write bus
      for (int j = 0; j < QN; j++) begin
        if (link_q[Q_RD][j].valid && link_q[Q_RD][j].want)
          expect_result(OK_RESP, ST_QUEUED, link_q[Q_RD][j].addr, '0,
                        link_q[Q_RD][j].meta, 1'b0);
        link_q[Q_RD][j].valid = 1'b0;
        link_q[Q_WR][j].valid = 1'b0;
      end
      model_wbusy = 1'b0;
      model_wslot = 0;
    end else begin
      // Return bus
      hold = 1'b0;
      if (model_sbusy) begin
        if (slot_ready(Q_RS, model_sslot)) begin
          expect_result(OK_RESP, ST_QUEUED, link_q[Q_RS][model_sslot].addr,
                        link_q[Q_RS][model_sslot].data, link_q[Q_RS][model_sslot].meta, 1'b0);
          link_q[Q_RS][model_sslot].valid = 1'b0;
          model_sbusy = 1'b0;
          model_sslot = 0;
        end else hold = 1'b1;
      end
      if (!hold) begin
        i = oldest_ready(Q_RS);
        if (i >= 0) begin
          link_q[Q_RS][i].rdy = now + 32'(cfg_rxf);
          model_sbusy = 1'b1;
          model_sslot = i;
        end
      end
      // Outgoing write bus
      if (model_wbusy && slot_ready(Q_WR, model_wslot)) begin
        expect_result(OK_LWRITE, ST_QUEUED, link_q[Q_WR][model_wslot].addr,
                      link_q[Q_WR][model_wslot].data, link_q[Q_WR][model_wslot].meta, 1'b0);
        link_q[Q_WR][model_wslot].valid = 1'b0;
        model_wbusy = 1'b0;
        model_wslot = 0;
      end
      if (!model_wbusy) begin
        i = oldest_ready(Q_WR);
        if (i >= 0) begin
          link_q[Q_WR][i].rdy = now + 32'(cfg_wxf);
          model_wbusy = 1'b1;
          model_wslot = i;
        end
      end
      // Issue every ready read, oldest first
      i = oldest_ready(Q_RD);
      while (i >= 0) begin
        expect_result(OK_LREAD, ST_QUEUED, link_q[Q_RD][i].addr, '0,
                      link_q[Q_RD][i].meta, 1'b0);
        link_q[Q_RD][i].valid = 1'b0;
        i = oldest_ready(Q_RD);
      end
    end
    expect_result(OK_TICK, ST_QUEUED, '0, 64'(now), '0, 1'b1);
    model_tick = now + 32'd1;
  endtask

  task automatic predict_link_step(kind_t k, logic [63:0] a, logic [63:0] p,
                                   logic [31:0] m, bit w);
    int wi, ri, rf, wf, sf;
    logic [63:0] fwd;
    wi = line_hit(Q_WR, a);
    ri = line_hit(Q_RD, a);
    rf = free_slot(Q_RD);
    wf = free_slot(Q_WR);
    sf = free_slot(Q_RS);
    case (k)
      K_TICK: predict_tick();
      K_READ: begin
        if (cfg_warmup) begin
          expect_result(OK_STATUS, ST_WU_ANS, a, '0, m, !w);
          if (w) expect_result(OK_RESP, ST_QUEUED, a, '0, m, 1'b1);
        end else if (wi >= 0) begin
          fwd = link_q[Q_WR][wi].data;
          expect_result(OK_STATUS, ST_FORWARDED, a, fwd, m, !w);
          if (w) expect_result(OK_RESP, ST_QUEUED, a, fwd, m, 1'b1);
        end else if (ri >= 0) begin
          link_q[Q_RD][ri].want = link_q[Q_RD][ri].want | w;
          expect_result(OK_STATUS, ST_COALESCED, a, '0, m, 1'b1);
        end else if (rf >= 0) begin
          fill_slot(Q_RD, rf, a, '0, m, w);
          expect_result(OK_STATUS, ST_QUEUED, a, '0, m, 1'b1);
        end else expect_result(OK_STATUS, ST_FULL, a, '0, m, 1'b1);
      end
      K_WRITE: begin
        if (cfg_warmup) begin
          expect_result(OK_STATUS, ST_WU_DROP, a, '0, m, 1'b1);
        end else if (wi >= 0) begin
          link_q[Q_WR][wi].data = p;
          link_q[Q_WR][wi].meta = m;
          expect_result(OK_STATUS, ST_COALESCED, a, '0, m, 1'b1);
        end else if (wf >= 0) begin
          fill_slot(Q_WR, wf, a, p, m, 1'b0);
          expect_result(OK_STATUS, ST_QUEUED, a, '0, m, 1'b1);
        end else expect_result(OK_STATUS, ST_FULL, a, '0, m, 1'b1);
      end
      default: begin
        if (sf >= 0) begin
          fill_slot(Q_RS, sf, a, p, m, 1'b1);
          expect_result(OK_STATUS, ST_QUEUED, a, '0, m, 1'b1);
        end else expect_result(OK_STATUS, ST_FULL, a, '0, m, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      result_t r;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d addr=%h", out_kind, out_address);
        errors++;
      end else begin
        r = pending_results.pop_front();
        if (out_kind !== r.kind) begin
          $error("out_kind: expected %0d, got %0d", r.kind, out_kind); errors++;
        end
        if (out_status !== r.st) begin
          $error("status: expected %0d, got %0d", r.st, out_status); errors++;
        end
        if (out_address !== r.addr) begin
          $error("out_address: expected %h, got %h", r.addr, out_address); errors++;
        end
        if (out_data !== r.data) begin
          $error("out_data: expected %h, got %h", r.data, out_data); errors++;
        end
        if (out_metadata !== r.meta) begin
          $error("out_metadata: expected %h, got %h", r.meta, out_metadata); errors++;
        end
        if (out_last !== r.last) begin
          $error("last: expected %0d, got %0d", r.last, out_last); errors++;
        end
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req_cnt != hold_seen_cnt) begin
      hold_seen_cnt <= hold_req_cnt;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending_results.size());
      $display("memory_link_request_scheduler_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_item(kind_t k, logic [63:0] a, logic [63:0] p,
                           logic [31:0] m, bit w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_address <= a;
    in_payload <= p;
    in_metadata <= m;
    in_wants_response <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_link_step(k, a, p, m, w);
    items_sent++;
  endtask

  // Wait for every expected result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      CFG_WARMUP: cfg_warmup = v[0];
      CFG_LAT:    cfg_lat = v[9:0];
      CFG_RXF:    cfg_rxf = v[9:0];
      default:    cfg_wxf = v[9:0];
    endcase
  endtask

  task automatic set_config(bit wu, int lat, int rxf, int wxf);
    cfg_write(CFG_WARMUP, 32'(wu));
    cfg_write(CFG_LAT, 32'(lat));
    cfg_write(CFG_RXF, 32'(rxf));
    cfg_write(CFG_WXF, 32'(wxf));
  endtask

  function automatic logic [63:0] rand_addr();
    if ($urandom_range(9) < 8) return {line_pool[$urandom_range(7)], 6'($urandom)};
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    set_config(1'b0, 2, 1, 1);
    send_item(K_WRITE, 64'h0, '1, '1, 1'b0);
    send_item(K_READ, 64'h3F, '0, 32'h0, 1'b1);           // forwarded, wants data
    send_item(K_READ, 64'h20, '0, 32'h1234, 1'b0);        // forwarded, no response
    send_item(K_WRITE, 64'h8, 64'hA5A5_0000_FFFF_1111, 32'h77, 1'b0); // replace
    send_item(K_READ, 64'h1, '0, 32'h5, 1'b0);            // forwards replaced data
    send_item(K_READ, '1, '0, '1, 1'b0);
    send_item(K_READ, 64'hFFFF_FFFF_FFFF_FFC0, '0, 32'h9, 1'b1); // coalesce
    send_item(K_RESP, '1, '1, '1, 1'b1);
    send_item(K_RESP, 64'h0, 64'h0, 32'h0, 1'b0);
    repeat (8) send_item(K_TICK, rand64(), rand64(), $urandom, 1'($urandom));
    drain();
  endtask

  task automatic test_queue_full();
    set_config(1'b0, 1, 1, 1);
    for (int i = 0; i < QN + 1; i++) begin
      send_item(K_READ, {58'(i + 100), 6'h0}, '0, 32'(i), 1'($urandom));
      send_item(K_WRITE, {58'(i + 300), 6'h0}, rand64(), 32'(i), 1'b0);
      send_item(K_RESP, {58'(i + 500), 6'h0}, rand64(), 32'(i), 1'b1);
    end
    repeat (40) send_item(K_TICK, '0, '0, '0, 1'b0);
    drain();
  endtask

  task automatic test_warmup();
    set_config(1'b0, 1023, 1023, 1023);
    send_item(K_READ, 64'h1000, '0, 32'h1, 1'b1);
    send_item(K_READ, 64'h2000, '0, 32'h2, 1'b0);
    send_item(K_WRITE, 64'h3000, 64'h33, 32'h3, 1'b0);
    send_item(K_TICK, '0, '0, '0, 1'b0);
    drain();
    cfg_write(CFG_WARMUP, 32'd1);
    send_item(K_READ, 64'h4000, '0, 32'h4, 1'b1);
    send_item(K_READ, 64'h4040, '0, 32'h5, 1'b0);
    send_item(K_WRITE, 64'h5000, 64'h55, 32'h6, 1'b0);
    send_item(K_RESP, 64'h6000, 64'h66, 32'h7, 1'b1);
    send_item(K_TICK, '0, '0, '0, 1'b0);
    drain();
  endtask

  task automatic test_random(int n, bit allow_warmup, bit mid_pause);
    int r;
    kind_t k;
    if ($urandom_range(3) == 0) set_config(1'b0, 1023, 1023, 1023);
    else set_config(allow_warmup && ($urandom_range(3) == 0), $urandom_range(1, 12),
                    $urandom_range(1, 6), $urandom_range(1, 6));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = (r < 35) ? K_TICK : (r < 60) ? K_READ : (r < 80) ? K_WRITE : K_RESP;
      send_item(k, rand_addr(), rand64(), $urandom, 1'($urandom));
      if (mid_pause && i == n / 2) begin
        drain();
        set_config(1'b0, 1, 1023, 1);
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    set_config(1'b0, 3, 2, 2);
    hold_req_cnt++;
    for (int i = 0; i < 40; i++)
      send_item(($urandom_range(2) == 0) ? K_TICK : K_READ, rand_addr(), rand64(),
                $urandom, 1'b1);
    drain();
  endtask

  initial begin
    for (int q = 0; q < 3; q++)
      for (int i = 0; i < QN; i++) link_q[q][i] = '{default: '0};
    model_tick = '0;
    model_wbusy = 1'b0; model_sbusy = 1'b0;
    model_wslot = 0; model_sslot = 0;
    cfg_warmup = 1'b0; cfg_lat = 10'd10; cfg_rxf = 10'd4; cfg_wxf = 10'd4;
    for (int i = 0; i < 8; i++) line_pool[i] = 58'({$urandom, $urandom});
    line_pool[0] = '0;
    line_pool[1] = '1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration first, then directed cases
    send_item(K_READ, 64'h40, '0, 32'hAB, 1'b1);
    repeat (12) send_item(K_TICK, '0, '0, '0, 1'b0);
    drain();
    test_directed();
    test_queue_full();
    test_warmup();

    send_idle_pct = 29; recv_idle_pct = 67;
    test_random(42, 1'b1, 1'b1);
    test_random(42, 1'b1, 1'b0);
    send_idle_pct = 67; recv_idle_pct = 29;
    test_random(42, 1'b1, 1'b0);
    test_random(42, 1'b0, 1'b0);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(42, 1'b1, 1'b0);
    test_random(42, 1'b0, 1'b0);
    test_backpressure();

    $display("covered %0d transactions in, %0d results out: forwarding, coalescing,",
             items_sent, results_seen);
    $display("write replace, full queues, warmup, extreme timings and long stalls");
    if (errors == 0) begin
      $display("memory_link_request_scheduler_tb: done, clean");
    end else begin
      $display("memory_link_request_scheduler_tb: done, errors");
    end
    $finish;
  end

endmodule
